// File: hw/rtl/aes128_block_encrypt_top_assert.svh
// Assertion macros for the AES-128 encrypt top module.
`ifndef AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define AES_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define AES_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define AES_ASSERT(lbl, prop)
`define AES_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: hw/rtl/aes128_enc_pkg.sv
// Types, constants and round functions for the AES-128 encrypt pipeline.
`default_nettype none
package aes128_enc_pkg;

  localparam int unsigned NR        = 10;
  localparam int unsigned BLK_W     = 128;
  localparam int unsigned HALF_W    = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned STEP_W    = $clog2(NR + 1);

  localparam logic [CFG_IDX_W-1:0] KEY_HIGH_IDX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] KEY_LOW_IDX  = CFG_IDX_W'(1);

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [NR:0][BLK_W-1:0] rk_arr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NR] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes and ShiftRows, then MixColumns when mix is set; byte i at bits 127-8i.
  function automatic blk_t round_fn(blk_t s, logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    blk_t       res;
    for (int i = 0; i < 16; i++) begin
      b[i] = s[BLK_W-1-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[b[4*((c+r)%4)+r]];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0  = t[4*c];
        a1  = t[4*c+1];
        a2  = t[4*c+2];
        a3  = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      res[BLK_W-1-8*i -: 8] = t[i];
    end
    return res;
  endfunction

  // One key expansion step: next round key from the previous one.
  function automatic blk_t next_rk(blk_t prev, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = prev[127:96];
    w1 = prev[95:64];
    w2 = prev[63:32];
    w3 = prev[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aes128_block_encrypt_top.sv
// AES-128 ECB encrypt: eleven-stage round pipeline with key expansion.
// Each pipeline stage holds one round, passing a word on in turn to the output register.
// Throughput: one word per cycle when not stalled; bubbles collapse.
// Reset: key clears to zero, then key expansion runs with in_stall_o high.
// Each write to a key register reruns the expansion, stalling input.
`default_nettype none
module aes128_block_encrypt_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [aes128_enc_pkg::HALF_W-1:0]    plain_high_i,
  input  logic [aes128_enc_pkg::HALF_W-1:0]    plain_low_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [aes128_enc_pkg::HALF_W-1:0]    cipher_high_o,
  output logic [aes128_enc_pkg::HALF_W-1:0]    cipher_low_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [aes128_enc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [aes128_enc_pkg::HALF_W-1:0]    cfg_data_i
);
  import aes128_enc_pkg::*;
`include "aes128_block_encrypt_top_assert.svh"

  rk_arr_t     rk;
  logic        key_busy;
  logic        v0_q;
  blk_t        st0_q;
  blk_t        st [NR+1];
  logic [NR:0] v;
  logic [NR+1:0] load;

  assign cfg_ready_o = 1'b1;

  aes128_enc_key_exp u_key_exp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .round_keys_o (rk),
    .busy_o       (key_busy)
  );

  assign load[NR+1] = !out_stall_i;
  for (genvar k = 0; k <= NR; k++) begin : g_load
    assign load[k] = !v[k] || load[k+1];
  end

  assign in_stall_o = key_busy || !load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (load[0]) begin
      v0_q <= in_valid_i && !key_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      st0_q <= {plain_high_i, plain_low_i} ^ rk[0];
    end
  end

  assign st[0] = st0_q;
  assign v[0]  = v0_q;

  for (genvar k = 1; k <= NR; k++) begin : g_round
    aes128_enc_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load[k]),
      .mix_i   (k != NR),
      .valid_i (v[k-1]),
      .state_i (st[k-1]),
      .rk_i    (rk[k]),
      .valid_o (v[k]),
      .state_o (st[k])
    );
  end

  assign out_valid_o   = v[NR];
  assign cipher_high_o = st[NR][BLK_W-1 -: HALF_W];
  assign cipher_low_o  = st[NR][HALF_W-1:0];

  `AES_ASSERT(a_key_write_blocks_input, cfg_valid_i && cfg_ready_o && (cfg_index_i == KEY_HIGH_IDX || cfg_index_i == KEY_LOW_IDX) |=> in_stall_o)
  `AES_ASSERT(a_accept_fills_first, in_valid_i && !in_stall_o |=> v0_q)
  `AES_ASSERT(a_output_drains, out_valid_o && !out_stall_i && !v[NR-1] |=> !out_valid_o)

endmodule
`default_nettype wire

// File: hw/rtl/aes128_enc_key_exp.sv
// Key registers and sequential key expansion into the round key store.
`default_nettype none
module aes128_enc_key_exp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [aes128_enc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [aes128_enc_pkg::HALF_W-1:0]    cfg_data_i,
  output aes128_enc_pkg::rk_arr_t              round_keys_o,
  output logic                                 busy_o
);
  import aes128_enc_pkg::*;

  logic [HALF_W-1:0] key_hi_q, key_hi_d, key_lo_q, key_lo_d;
  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  blk_t              cur_q, cur_d;
  rk_arr_t           rk_q;
  logic              wr_hi, wr_lo;

  assign wr_hi = cfg_valid_i && (cfg_index_i == KEY_HIGH_IDX);
  assign wr_lo = cfg_valid_i && (cfg_index_i == KEY_LOW_IDX);

  always_comb begin
    key_hi_d = wr_hi ? cfg_data_i : key_hi_q;
    key_lo_d = wr_lo ? cfg_data_i : key_lo_q;
    busy_d   = busy_q;
    step_d   = step_q;
    cur_d    = cur_q;
    if (busy_q) begin
      cur_d  = (step_q == '0) ? {key_hi_q, key_lo_q} : next_rk(cur_q, RCON[step_q - 1'b1]);
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(NR)) begin
        busy_d = 1'b0;
      end
    end
    if (wr_hi || wr_lo) begin
      busy_d = 1'b1;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      busy_q   <= 1'b1;
      step_q   <= '0;
    end else begin
      key_hi_q <= key_hi_d;
      key_lo_q <= key_lo_d;
      busy_q   <= busy_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (busy_q) begin
      rk_q[step_q] <= cur_d;
    end
  end

  assign round_keys_o = rk_q;
  assign busy_o       = busy_q;

endmodule
`default_nettype wire

// File: hw/rtl/aes128_enc_round.sv
// One registered cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
`default_nettype none
module aes128_enc_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  mix_i,
  input  logic                  valid_i,
  input  aes128_enc_pkg::blk_t  state_i,
  input  aes128_enc_pkg::blk_t  rk_i,
  output logic                  valid_o,
  output aes128_enc_pkg::blk_t  state_o
);
  import aes128_enc_pkg::*;

  logic valid_q;
  blk_t state_q, state_d;

  assign state_d = round_fn(state_i, mix_i) ^ rk_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule
`default_nettype wire
